/* src/dkd_pkg.sv */
package dkd_pkg;

   // fixed-point format
   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 24;
   localparam int INV_W      = 32;
   localparam int SCALE_W    = 40;
   localparam int WEIGHT_W   = 40;

   // lane internals
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = DIFF_W + INV_W;
   localparam int R_W        = FRAC_BITS + 2;
   localparam int SQ_W       = 2 * R_W;
   localparam int SQRT_STEPS = FRAC_BITS + 2;
   localparam int ROOT_W     = SQRT_STEPS;
   localparam int REM_W      = 2 * SQRT_STEPS + 1;
   localparam int CALC_W     = 2 * FRAC_BITS + 8;
   localparam int NUM_W      = FRAC_BITS + 6;
   localparam int AXW_W      = FRAC_BITS + 1;

   // merge internals
   localparam int P_W        = AXW_W + 1;
   localparam int SPLIT      = SCALE_W / 2;
   localparam int PART_W     = P_W + SCALE_W - SPLIT;
   localparam int SUM_W      = P_W + SCALE_W;

   // latencies
   localparam int LANE_LAT   = 5 + SQRT_STEPS;
   localparam int MERGE_LAT  = 3;
   localparam int PIPE_LAT   = LANE_LAT + MERGE_LAT;

   // register indexes
   typedef enum logic {
      CSR_INV_SPACING  = 1'b0,
      CSR_WEIGHT_SCALE = 1'b1
   } csr_index_type;

   localparam logic [INV_W-1:0]   INV_RESET   = INV_W'(1) << FRAC_BITS;
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1) << FRAC_BITS;

endpackage

/* src/dkd_lane.sv */
module dkd_lane (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [dkd_pkg::COORD_W-1:0]   a,
   input  logic signed [dkd_pkg::COORD_W-1:0]   b,
   input  logic        [dkd_pkg::INV_W-1:0]     inv_spacing,
   output logic        [dkd_pkg::AXW_W-1:0]     axis_weight
);

   localparam int F = dkd_pkg::FRAC_BITS;
   localparam int N = dkd_pkg::SQRT_STEPS;

   logic [dkd_pkg::DIFF_W-1:0]  d_ff, d_in;
   logic [dkd_pkg::PROD_W-1:0]  prod_ff;
   logic [dkd_pkg::R_W-1:0]     r3_ff, r3_in;
   logic                        far3_ff, far3_in;
   logic [dkd_pkg::SQ_W-1:0]    sq3_ff;
   logic [dkd_pkg::PROD_W-F-1:0] ru;

   logic [dkd_pkg::REM_W-1:0]   rem_ff  [0:N];
   logic [dkd_pkg::ROOT_W-1:0]  root_ff [0:N];
   logic [dkd_pkg::R_W-1:0]     r_ff    [0:N];
   logic                        near_ff [0:N];
   logic                        far_ff  [0:N];

   logic signed [dkd_pkg::CALC_W-1:0] rs, sqs, rad_near, rad_far, rad;
   logic signed [dkd_pkg::NUM_W-1:0]  num, r2s, ss;
   logic [dkd_pkg::AXW_W-1:0]   w_ff, w_in;

   // absolute separation
   always_comb begin
      logic signed [dkd_pkg::DIFF_W-1:0] diff;
      diff = dkd_pkg::DIFF_W'(a) - dkd_pkg::DIFF_W'(b);
      d_in = diff[dkd_pkg::DIFF_W-1] ? dkd_pkg::DIFF_W'(-diff) : dkd_pkg::DIFF_W'(diff);
   end

   // scaled distance, range check, square of r
   assign ru      = prod_ff[dkd_pkg::PROD_W-1:F];
   assign far3_in = ru > (dkd_pkg::PROD_W-F)'(2) << F;
   assign r3_in   = ru[dkd_pkg::R_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         prod_ff <= dkd_pkg::PROD_W'(d_ff) * dkd_pkg::PROD_W'(inv_spacing);
         r3_ff   <= r3_in;
         far3_ff <= far3_in;
         sq3_ff  <= dkd_pkg::SQ_W'(r3_in) * dkd_pkg::SQ_W'(r3_in);
      end
   end

   // radicand in Q.2F for both branches
   assign rs       = $signed(dkd_pkg::CALC_W'(r3_ff));
   assign sqs      = $signed(dkd_pkg::CALC_W'(sq3_ff)) <<< 2;
   assign rad_near = ($signed(dkd_pkg::CALC_W'(1)) <<< (2 * F)) + (rs <<< (F + 2)) - sqs;
   assign rad_far  = (rs <<< (F + 3)) + (rs <<< (F + 2)) - sqs
                   - ($signed(dkd_pkg::CALC_W'(7)) <<< (2 * F));
   assign rad      = (r3_ff <= dkd_pkg::R_W'(1) << F) ? rad_near : rad_far;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= (far3_ff || rad[dkd_pkg::CALC_W-1]) ? '0
                       : rad[dkd_pkg::REM_W-1:0];
         root_ff[0] <= '0;
         r_ff[0]    <= r3_ff;
         near_ff[0] <= r3_ff <= dkd_pkg::R_W'(1) << F;
         far_ff[0]  <= far3_ff;
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < N; k++) begin : g_sqrt
      localparam int B = N - 1 - k;
      logic [dkd_pkg::REM_W-1:0] trial;
      assign trial = (dkd_pkg::REM_W'(root_ff[k]) << (B + 1))
                   | (dkd_pkg::REM_W'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[k] >= trial) begin
               rem_ff[k+1]  <= rem_ff[k] - trial;
               root_ff[k+1] <= root_ff[k] | (dkd_pkg::ROOT_W'(1) << B);
            end else begin
               rem_ff[k+1]  <= rem_ff[k];
               root_ff[k+1] <= root_ff[k];
            end
            r_ff[k+1]    <= r_ff[k];
            near_ff[k+1] <= near_ff[k];
            far_ff[k+1]  <= far_ff[k];
         end
      end
   end

   // numerator, clamp, divide by eight
   assign r2s = $signed(dkd_pkg::NUM_W'(r_ff[N])) <<< 1;
   assign ss  = $signed(dkd_pkg::NUM_W'(root_ff[N]));
   assign num = near_ff[N]
              ? ($signed(dkd_pkg::NUM_W'(3)) <<< F) - r2s + ss
              : ($signed(dkd_pkg::NUM_W'(5)) <<< F) - r2s - ss;

   always_comb begin
      if (far_ff[N] || num[dkd_pkg::NUM_W-1]) w_in = '0;
      else w_in = num[dkd_pkg::AXW_W+2:3];
   end

   always_ff @(posedge clock) begin
      if (en) w_ff <= w_in;
   end

   assign axis_weight = w_ff;

endmodule

/* src/dkd_merge.sv */
module dkd_merge (
   input  logic                               clock,
   input  logic                               en,
   input  logic [dkd_pkg::AXW_W-1:0]          wx,
   input  logic [dkd_pkg::AXW_W-1:0]          wy,
   input  logic [dkd_pkg::SCALE_W-1:0]        weight_scale,
   output logic [dkd_pkg::WEIGHT_W-1:0]       weight
);

   localparam int F = dkd_pkg::FRAC_BITS;
   localparam int S = dkd_pkg::SPLIT;

   logic [2*dkd_pkg::AXW_W-1:0]   pxy;
   logic [dkd_pkg::P_W-1:0]       p_ff;
   logic [dkd_pkg::PART_W-1:0]    lo_ff, hi_ff;
   logic [dkd_pkg::SUM_W-1:0]     sum;
   logic [dkd_pkg::SUM_W-F-1:0]   shifted;
   logic [dkd_pkg::WEIGHT_W-1:0]  weight_ff, weight_in;

   assign pxy = (2*dkd_pkg::AXW_W)'(wx) * (2*dkd_pkg::AXW_W)'(wy);

   // product of the axis weights, then scale in two halves
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff  <= dkd_pkg::P_W'(pxy >> F);
         lo_ff <= dkd_pkg::PART_W'(p_ff) * dkd_pkg::PART_W'(weight_scale[S-1:0]);
         hi_ff <= dkd_pkg::PART_W'(p_ff)
                * dkd_pkg::PART_W'(weight_scale[dkd_pkg::SCALE_W-1:S]);
      end
   end

   // recombine and saturate
   assign sum     = dkd_pkg::SUM_W'(lo_ff) + (dkd_pkg::SUM_W'(hi_ff) << S);
   assign shifted = sum[dkd_pkg::SUM_W-1:F];
   assign weight_in = (shifted > (dkd_pkg::SUM_W-F)'({dkd_pkg::WEIGHT_W{1'b1}}))
                    ? {dkd_pkg::WEIGHT_W{1'b1}}
                    : shifted[dkd_pkg::WEIGHT_W-1:0];

   always_ff @(posedge clock) begin
      if (en) weight_ff <= weight_in;
   end

   assign weight = weight_ff;

endmodule

/* src/discrete_delta_kernel_2d_core.sv */
// Channel  Direction  Handshake              Payload
// req_     in         req_valid / req_stall  cell_x, cell_y, marker_x, marker_y
// rsp_     out        rsp_valid / rsp_stall  weight
// csr_     in         csr_valid / csr_ready  csr_index, csr_data
//
// One pair per cycle while no held result stalls the pipe; most of its depth is
// the 18-stage square-root pipe in each axis lane.
// Synchronous active-high reset clears valids and reloads both registers.
// A held result stalls the whole pipe; req_stall follows it in the same cycle.
module discrete_delta_kernel_2d_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [dkd_pkg::COORD_W-1:0]  req_cell_x,
   input  logic signed [dkd_pkg::COORD_W-1:0]  req_cell_y,
   input  logic signed [dkd_pkg::COORD_W-1:0]  req_marker_x,
   input  logic signed [dkd_pkg::COORD_W-1:0]  req_marker_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [dkd_pkg::WEIGHT_W-1:0] rsp_weight,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic        [dkd_pkg::SCALE_W-1:0]  csr_data
);

   logic                              en;
   logic [dkd_pkg::PIPE_LAT-1:0]      vld_ff;
   logic [dkd_pkg::INV_W-1:0]         inv_ff;
   logic [dkd_pkg::SCALE_W-1:0]       scale_ff;
   logic [dkd_pkg::AXW_W-1:0]         wx, wy;

   assign en        = !(vld_ff[dkd_pkg::PIPE_LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[dkd_pkg::PIPE_LAT-1];
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff   <= dkd_pkg::INV_RESET;
         scale_ff <= dkd_pkg::SCALE_RESET;
      end else if (csr_valid) begin
         case (dkd_pkg::csr_index_type'(csr_index))
            dkd_pkg::CSR_INV_SPACING:  inv_ff   <= csr_data[dkd_pkg::INV_W-1:0];
            dkd_pkg::CSR_WEIGHT_SCALE: scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // valid line alongside the datapath
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[dkd_pkg::PIPE_LAT-2:0], req_valid};
   end

   dkd_lane u_lane_x (
      .clock(clock), .en(en), .a(req_cell_x), .b(req_marker_x),
      .inv_spacing(inv_ff), .axis_weight(wx)
   );

   dkd_lane u_lane_y (
      .clock(clock), .en(en), .a(req_cell_y), .b(req_marker_y),
      .inv_spacing(inv_ff), .axis_weight(wy)
   );

   dkd_merge u_merge (
      .clock(clock), .en(en), .wx(wx), .wy(wy),
      .weight_scale(scale_ff), .weight(rsp_weight)
   );

endmodule

/* src/dkd_checker.sv */
module dkd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [dkd_pkg::WEIGHT_W-1:0]       rsp_weight
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input is held back only by a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall without held result");

   // held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight))
      else $error("held result changed");

endmodule

bind discrete_delta_kernel_2d_core dkd_checker u_dkd_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_weight(rsp_weight)
);
